@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL of the window average select unit.
// Depends on nothing; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Implication checked on every clock edge while out of reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition that must never be true while out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

@@ src/mwas_pkg.sv @@
// Shared types, register codes and defaults of the window average select unit.
// Depends on nothing; the RTL modules and the testbench import it.
package mwas_pkg;

	localparam int CHANNELS_DEF    = 4;
	localparam int WINDOW_MAX_DEF  = 16;
	localparam int SAMPLE_BITS_DEF = 12;

	localparam int IN_FIELDS  = 4;
	localparam int IN_BITS    = 12;
	localparam int VALUE_BITS = 12;
	localparam int CH_BITS    = 2;
	localparam int SEL_BITS   = 2;
	localparam int CNT_BITS   = 3;
	localparam int SEL_LIST_BITS = 8;
	localparam int REG_IDX_BITS  = 3;
	localparam int WLEN_IN_BITS  = 5;

	localparam int WINDOW_RESET = 4;
	localparam logic [CNT_BITS-1:0] CHANNEL_COUNT_RESET = 3'd4;

	localparam logic [REG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_WINDOW_LENGTH = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_USE_AVERAGE   = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_SELECT_COUNT  = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_SELECT_LIST   = 3'd4;

	typedef struct packed {
		logic [IN_BITS-1:0] sample_3;
		logic [IN_BITS-1:0] sample_2;
		logic [IN_BITS-1:0] sample_1;
		logic [IN_BITS-1:0] sample_0;
	} frame_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [CH_BITS-1:0]    channel;
		logic                  last;
	} result_t;

	typedef struct packed {
		logic [REG_IDX_BITS-1:0]  index;
		logic [SEL_LIST_BITS-1:0] value;
	} cfg_word_t;

	typedef struct packed {
		logic [CNT_BITS-1:0]      chan_count;
		logic                     use_avg;
		logic [CNT_BITS-1:0]      sel_count;
		logic [SEL_LIST_BITS-1:0] sel_list;
	} cfg_t;

	typedef struct packed {
		logic               load;
		logic               write;
		logic               sweep;
		logic               div_start;
		logic               emit;
		logic               avg;
		logic [CH_BITS-1:0] ch;
		logic               last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic sweep_done;
		logic div_busy;
		logic out_free;
	} dp_status_t;

endpackage

@@ src/mwas_stream_if.sv @@
// Valid/ready channel carrying one word of payload type T.
// Depends on nothing; payload types come from mwas_pkg at the instance.
interface mwas_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ src/mwas_div.sv @@
// Restoring divider, one quotient bit per cycle, for the window means.
// Depends on mwas_pkg.
module mwas_div import mwas_pkg::*; #(
	parameter int NUM_BITS = 17,
	parameter int DEN_BITS = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] dividend,
	input  logic [DEN_BITS-1:0] divisor,
	output logic                busy,
	output logic [NUM_BITS-1:0] quotient
);

	localparam int CW = $clog2(NUM_BITS + 1);

	logic [DEN_BITS-1:0] rem_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q;
	logic [DEN_BITS:0]   shifted;
	logic [DEN_BITS:0]   diff;

	assign shifted = {rem_q, quo_q[NUM_BITS-1]};
	assign diff    = shifted - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NUM_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// The top bit of diff is the borrow: set when the divisor does not fit.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!diff[DEN_BITS]) begin
				rem_q <= diff[DEN_BITS-1:0];
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DEN_BITS-1:0];
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

@@ src/mwas_datapath.sv @@
// Datapath: frame capture, history ring memory, per-lane window sums,
// divider and the output register. Depends on mwas_pkg and mwas_div.
module mwas_datapath import mwas_pkg::*; #(
	parameter int CHANNELS    = CHANNELS_DEF,
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	localparam int WLW        = $clog2(WINDOW_MAX + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ctrl_cmd_t      cmd,
	output dp_status_t     st,
	input  frame_t         frame,
	input  logic [WLW-1:0] wlen,
	input  logic           restart,
	output logic           out_valid,
	output result_t        out_data,
	input  logic           out_ready
);

	localparam int LANES = (CHANNELS < IN_FIELDS) ? CHANNELS : IN_FIELDS;
	localparam int WPW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int SUMW  = SAMPLE_BITS + WLW;
	localparam int CHW   = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int RW    = LANES * SAMPLE_BITS;

	logic [IN_BITS-1:0]     smp [IN_FIELDS];
	logic [SAMPLE_BITS-1:0] raw_q [LANES];
	logic [RW-1:0]          ring_mem [WINDOW_MAX];
	logic [RW-1:0]          row;
	logic [RW-1:0]          rd_s1;
	logic                   rdv_s1;
	logic [SUMW-1:0]        sum_q [LANES];
	logic [WPW-1:0]         wpos_q;
	logic [WLW-1:0]         fill_q;
	logic [WLW-1:0]         rptr_q;
	logic [WLW:0]           wnext;
	logic                   out_valid_q;
	result_t                out_q;
	logic [SUMW-1:0]        quotient;
	logic                   div_busy;
	logic [31:0]            val_w;
	logic [CHW-1:0]         lane;

	assign smp[0] = frame.sample_0;
	assign smp[1] = frame.sample_1;
	assign smp[2] = frame.sample_2;
	assign smp[3] = frame.sample_3;
	assign lane   = cmd.ch[CHW-1:0];
	assign wnext  = (WLW + 1)'(wpos_q) + 1'b1;

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			row[l*SAMPLE_BITS +: SAMPLE_BITS] = raw_q[l];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int l = 0; l < LANES; l++) begin
				raw_q[l] <= SAMPLE_BITS'(smp[l]);
			end
		end
	end

	// Ring memory: one row per frame, all lanes side by side.
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			ring_mem[wpos_q] <= row;
		end
	end

	always_ff @(posedge clk) begin
		rd_s1 <= ring_mem[rptr_q[WPW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0;
			fill_q <= '0;
		end else if (restart) begin
			wpos_q <= '0;
			fill_q <= '0;
		end else if (cmd.write) begin
			if (wnext >= {1'b0, wlen}) begin
				wpos_q <= '0;
			end else begin
				wpos_q <= wnext[WPW-1:0];
			end
			if (fill_q < wlen) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// The sweep reads rows 0 to fill-1; each read is registered in rd_s1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_q <= '0;
			rdv_s1 <= 1'b0;
		end else begin
			rdv_s1 <= cmd.sweep && (rptr_q < fill_q);
			if (cmd.write) begin
				rptr_q <= '0;
			end else if (cmd.sweep && (rptr_q < fill_q)) begin
				rptr_q <= rptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (cmd.write) begin
				sum_q[l] <= '0;
			end else if (rdv_s1) begin
				sum_q[l] <= sum_q[l] + SUMW'(rd_s1[l*SAMPLE_BITS +: SAMPLE_BITS]);
			end
		end
	end

	mwas_div #(
		.NUM_BITS(SUMW),
		.DEN_BITS(WLW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(sum_q[lane]),
		.divisor (fill_q),
		.busy    (div_busy),
		.quotient(quotient)
	);

	assign val_w = cmd.avg ? 32'(quotient) : 32'(raw_q[lane]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.value   <= val_w[VALUE_BITS-1:0];
			out_q.channel <= cmd.ch;
			out_q.last    <= cmd.last;
		end
	end

	assign st.sweep_done = (rptr_q == fill_q) && !rdv_s1;
	assign st.div_busy   = div_busy;
	assign st.out_free   = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_q;

endmodule

@@ src/mwas_ctrl.sv @@
// Controller: sequences write, sweep and divide (average mode only) and emit
// for each frame and works out the channel order. Depends on mwas_pkg.
module mwas_ctrl import mwas_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	output ctrl_cmd_t  cmd,
	input  dp_status_t st
);

	localparam int LANES = (CHANNELS < IN_FIELDS) ? CHANNELS : IN_FIELDS;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_WRITE = 6'b000010,
		S_SWEEP = 6'b000100,
		S_PICK  = 6'b001000,
		S_DIV   = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [CH_BITS-1:0]  k_q;
	logic [CNT_BITS-1:0] n_act;
	logic [CNT_BITS-1:0] m_out;
	logic [CH_BITS-1:0]  entry;
	logic [CH_BITS-1:0]  ch;
	logic                all_sel;
	logic                last;

	// Active channels clamped to 1..LANES; output count clamped to that.
	always_comb begin
		if (cfg.chan_count == '0) begin
			n_act = CNT_BITS'(1);
		end else if (32'(cfg.chan_count) > LANES) begin
			n_act = CNT_BITS'(LANES);
		end else begin
			n_act = cfg.chan_count;
		end
		all_sel = (cfg.sel_count == '0);
		if (all_sel || (cfg.sel_count > n_act)) begin
			m_out = n_act;
		end else begin
			m_out = cfg.sel_count;
		end
		entry = cfg.sel_list[{k_q, 1'b0} +: SEL_BITS];
		if (all_sel) begin
			ch = k_q;
		end else if ({1'b0, entry} >= n_act) begin
			ch = '0;
		end else begin
			ch = entry;
		end
		last = (({1'b0, k_q} + 1'b1) == m_out);
	end

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.avg       = cfg.use_avg;
		cmd.ch        = ch;
		cmd.last      = last;
		in_ready      = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				state_d   = cfg.use_avg ? S_SWEEP : S_PICK;
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (st.sweep_done) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				if (cfg.use_avg) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_DIV: begin
				if (!st.div_busy) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = last ? S_IDLE : S_PICK;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				k_q <= '0;
			end else if (cmd.emit) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

endmodule

@@ src/mwas_cfg.sv @@
// Configuration registers and the ring restart on a window length write.
// Depends on mwas_pkg.
module mwas_cfg import mwas_pkg::*; #(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF,
	localparam int WLW       = $clog2(WINDOW_MAX + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  cfg_word_t      word,
	output cfg_t           cfg,
	output logic [WLW-1:0] wlen,
	output logic           restart
);

	localparam int WLEN_RST = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;

	cfg_t                    cfg_q;
	logic [WLW-1:0]          wlen_q;
	logic [WLEN_IN_BITS-1:0] wl_in;
	logic [WLW-1:0]          wl_clamped;

	assign wl_in = word.value[WLEN_IN_BITS-1:0];

	always_comb begin
		if (wl_in == '0) begin
			wl_clamped = WLW'(1);
		end else if (32'(wl_in) > WINDOW_MAX) begin
			wl_clamped = WLW'(WINDOW_MAX);
		end else begin
			wl_clamped = WLW'(wl_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chan_count <= CHANNEL_COUNT_RESET;
			cfg_q.use_avg    <= 1'b0;
			cfg_q.sel_count  <= '0;
			cfg_q.sel_list   <= '0;
			wlen_q           <= WLW'(WLEN_RST);
		end else if (wr) begin
			case (word.index)
				REG_CHANNEL_COUNT: cfg_q.chan_count <= word.value[CNT_BITS-1:0];
				REG_WINDOW_LENGTH: wlen_q           <= wl_clamped;
				REG_USE_AVERAGE:   cfg_q.use_avg    <= word.value[0];
				REG_SELECT_COUNT:  cfg_q.sel_count  <= word.value[CNT_BITS-1:0];
				REG_SELECT_LIST:   cfg_q.sel_list   <= word.value;
				default: begin
				end
			endcase
		end
	end

	assign restart = wr && (word.index == REG_WINDOW_LENGTH);
	assign cfg     = cfg_q;
	assign wlen    = wlen_q;

endmodule

@@ src/multichannel_window_average_select_unit.sv @@
// Each input word is one frame of up to four samples. The frame is stored in a
// per-channel history ring, then one result word per selected channel is sent,
// in selection order, with last set on the final one; a result is either the
// raw sample or the truncated mean of the filled ring entries. Only one frame
// is in work at a time. In average mode the ring memory delivers one row per
// cycle for the sum, and the shared divider, whose quotient is SUMW =
// SAMPLE_BITS + clog2(WINDOW_MAX + 1) bits wide, gives one quotient bit per
// cycle. The next frame is taken while the last result still waits in the
// output register. Writing the window length register restarts the ring.
// Depends on mwas_pkg, mwas_stream_if, mwas_cfg, mwas_ctrl and mwas_datapath.
`include "assert_macros.svh"

module multichannel_window_average_select_unit import mwas_pkg::*; #(
	parameter int CHANNELS    = CHANNELS_DEF,
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mwas_stream_if.sink   in,
	mwas_stream_if.source out,
	mwas_stream_if.sink   cfg
);

	localparam int WLW = $clog2(WINDOW_MAX + 1);

	cfg_t           cfg_regs;
	logic [WLW-1:0] wlen;
	logic           restart;
	ctrl_cmd_t      cmd;
	dp_status_t     st;
	logic           in_ready;
	result_t        out_word;

	assign cfg.ready = 1'b1;

	mwas_cfg #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg.valid),
		.word   (cfg.data),
		.cfg    (cfg_regs),
		.wlen   (wlen),
		.restart(restart)
	);

	mwas_ctrl #(
		.CHANNELS(CHANNELS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_regs),
		.in_valid(in.valid),
		.in_ready(in_ready),
		.cmd     (cmd),
		.st      (st)
	);

	mwas_datapath #(
		.CHANNELS   (CHANNELS),
		.WINDOW_MAX (WINDOW_MAX),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.frame    (in.data),
		.wlen     (wlen),
		.restart  (restart),
		.out_valid(out.valid),
		.out_data (out_word),
		.out_ready(out.ready)
	);

	assign in.ready = in_ready;
	assign out.data = out_word;

	// A frame is taken only when the controller is free again.
	`ASSERT_PROP(a_one_frame, clk, arst_n, in.valid && in.ready |=> !in.ready, "frame accepted while busy")
	// The divider is never restarted while a division is running.
	`ASSERT_NEVER(a_div_overlap, clk, arst_n, cmd.div_start && st.div_busy, "divider restarted while busy")
	// A result only goes into the output register when it is empty or the held word leaves.
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, cmd.emit && out.valid && !out.ready, "result overwritten")

endmodule

@@ verif/tb_multichannel_window_average_select_unit.sv @@
// Self-checking testbench of multichannel_window_average_select_unit: frames go in,
// selected raw or window-mean results are predicted and compared word by word.
// Depends on mwas_pkg, mwas_stream_if and the unit itself.
`timescale 1ns / 100ps

module tb_multichannel_window_average_select_unit;
	import mwas_pkg::*;

	localparam int RING_ROWS  = WINDOW_MAX_DEF;
	localparam int LANES      = IN_FIELDS;
	localparam int HOLD_OFF   = 400;
	localparam int DRAIN_WAIT = 5000;
	localparam int IDLE_PCT   = 32;

	logic clk;
	logic arst_n;

	mwas_stream_if #(.T(frame_t))    frame_ch();
	mwas_stream_if #(.T(result_t))   result_ch();
	mwas_stream_if #(.T(cfg_word_t)) cfg_ch();

	multichannel_window_average_select_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(frame_ch),
		.out(result_ch),
		.cfg(cfg_ch)
	);

	// Predicted copy of the unit's state and registers.
	logic [VALUE_BITS-1:0] hist_ring [RING_ROWS][LANES];
	int unsigned wr_pos;
	int unsigned fill_rows;
	int unsigned chan_count;
	int unsigned win_len;
	int unsigned use_avg;
	int unsigned sel_count;
	int unsigned sel_list;

	result_t pending_results [$];

	int errors;
	int frames_sent;
	int results_checked;
	int reg_writes;
	bit calm;
	bit hold_req;
	bit hold_out;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#8ms;
		$display("Timeout at %0t with %0d results outstanding", $time, pending_results.size());
		$display("CHECK FAILED");
		$finish;
	end

	task automatic restart_ring(input int unsigned w);
		if (w < 1)
			w = 1;
		if (w > RING_ROWS)
			w = RING_ROWS;
		win_len = w;
		wr_pos = 0;
		fill_rows = 0;
	endtask

	task automatic apply_reg(input logic [REG_IDX_BITS-1:0] idx,
			input logic [SEL_LIST_BITS-1:0] val);
		case (idx)
			REG_CHANNEL_COUNT: chan_count = val & 8'h07;
			REG_WINDOW_LENGTH: restart_ring(val & 8'h1f);
			REG_USE_AVERAGE:   use_avg = val & 8'h01;
			REG_SELECT_COUNT:  sel_count = val & 8'h07;
			REG_SELECT_LIST:   sel_list = val;
			default: ;
		endcase
	endtask

	// Store the frame, then queue one result per selected channel.
	task automatic predict_frame(input frame_t f);
		logic [VALUE_BITS-1:0] raw [LANES];
		int unsigned n;
		int unsigned m;
		int unsigned ch;
		int unsigned sum;
		int unsigned v;
		bit all_ch;
		result_t r;
		raw[0] = f.sample_0;
		raw[1] = f.sample_1;
		raw[2] = f.sample_2;
		raw[3] = f.sample_3;
		for (int c = 0; c < LANES; c++)
			hist_ring[wr_pos][c] = raw[c];
		wr_pos = (wr_pos + 1 >= win_len) ? 0 : wr_pos + 1;
		if (fill_rows < win_len)
			fill_rows++;
		n = (chan_count < 1) ? 1 : (chan_count > LANES) ? LANES : chan_count;
		all_ch = (sel_count == 0);
		m = all_ch ? n : (sel_count > n ? n : sel_count);
		for (int k = 0; k < m; k++) begin
			if (all_ch) begin
				ch = k;
			end else begin
				ch = (sel_list >> (SEL_BITS * k)) & 3;
				if (ch >= n)
					ch = 0;
			end
			if (use_avg != 0) begin
				sum = 0;
				for (int i = 0; i < fill_rows; i++)
					sum += hist_ring[i][ch];
				v = sum / fill_rows;
			end else begin
				v = raw[ch];
			end
			r.value = v[VALUE_BITS-1:0];
			r.channel = ch[CH_BITS-1:0];
			r.last = (k + 1 == m);
			pending_results.push_back(r);
		end
	endtask

	// Sender: valid stays high from one word to the next unless an idle cycle falls.
	task automatic send_frame(input frame_t f);
		@(negedge clk);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			frame_ch.valid <= 1'b0;
			@(negedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.data <= f;
		do
			@(posedge clk);
		while (!frame_ch.ready);
		predict_frame(f);
		frames_sent++;
	endtask

	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
			input logic [SEL_LIST_BITS-1:0] val);
		cfg_word_t w;
		w.index = idx;
		w.value = val;
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= w;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		apply_reg(idx, val);
		reg_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		int guard;
		@(negedge clk);
		frame_ch.valid <= 1'b0;
		guard = 0;
		while (pending_results.size() != 0 && guard < DRAIN_WAIT) begin
			@(posedge clk);
			guard++;
		end
		if (pending_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				pending_results.size());
			errors++;
			pending_results.delete();
		end
	endtask

	function automatic logic [IN_BITS-1:0] rand_sample();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return IN_BITS'($urandom_range(4095));
		endcase
	endfunction

	function automatic frame_t rand_frame();
		frame_t f;
		f.sample_0 = rand_sample();
		f.sample_1 = rand_sample();
		f.sample_2 = rand_sample();
		f.sample_3 = rand_sample();
		return f;
	endfunction

	function automatic frame_t make_frame(input logic [IN_BITS-1:0] s0, s1, s2, s3);
		frame_t f;
		f.sample_0 = s0;
		f.sample_1 = s1;
		f.sample_2 = s2;
		f.sample_3 = s3;
		return f;
	endfunction

	// Receiver ready, changed at the falling edge only.
	always @(negedge clk)
		result_ch.ready <= arst_n && !hold_out && (calm || $urandom_range(99) >= IDLE_PCT);

	// Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
	initial begin
		hold_out = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_out = 1'b1;
				repeat (HOLD_OFF) @(posedge clk);
				hold_out = 1'b0;
				hold_req = 1'b0;
			end
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		result_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word value %0d channel %0d last %0d",
					$time, got.value, got.channel, got.last);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.value !== want.value) begin
					$display("%0t: value expected %0d, actual %0d", $time,
						want.value, got.value);
					errors++;
				end
				if (got.channel !== want.channel) begin
					$display("%0t: channel expected %0d, actual %0d", $time,
						want.channel, got.channel);
					errors++;
				end
				if (got.last !== want.last) begin
					$display("%0t: last expected %0d, actual %0d", $time,
						want.last, got.last);
					errors++;
				end
			end
			results_checked++;
		end
	end

	// Reset values, raw samples of all four channels.
	task automatic test_reset_defaults();
		send_frame(make_frame(12'h000, 12'h000, 12'h000, 12'h000));
		send_frame(make_frame(12'hfff, 12'hfff, 12'hfff, 12'hfff));
		send_frame(make_frame(12'haaa, 12'h555, 12'haaa, 12'h555));
		send_frame(make_frame(12'h001, 12'h800, 12'h7ff, 12'hffe));
		wait_idle();
	endtask

	// Means over a short window, through the fill and past the wrap.
	task automatic test_window_average();
		write_reg(REG_USE_AVERAGE, 8'd1);
		write_reg(REG_WINDOW_LENGTH, 8'd3);
		send_frame(make_frame(12'hfff, 12'h000, 12'd7, 12'd1));
		send_frame(make_frame(12'hfff, 12'h000, 12'd8, 12'd2));
		send_frame(make_frame(12'hffe, 12'hfff, 12'd9, 12'd2));
		send_frame(make_frame(12'h000, 12'hfff, 12'd1, 12'd0));
		wait_idle();
		// Zero is taken as one; the rewrite also restarts the ring.
		write_reg(REG_WINDOW_LENGTH, 8'd0);
		send_frame(make_frame(12'd5, 12'd6, 12'd7, 12'd8));
		send_frame(make_frame(12'd9, 12'd10, 12'd11, 12'd12));
		wait_idle();
		// Upper bits of the written word are dropped: 0xE3 gives three.
		write_reg(REG_WINDOW_LENGTH, 8'he3);
		send_frame(make_frame(12'd3, 12'd3, 12'd3, 12'd3));
		wait_idle();
		// Above the maximum is stored as the maximum.
		write_reg(REG_WINDOW_LENGTH, 8'd31);
		send_frame(make_frame(12'hfff, 12'hfff, 12'hfff, 12'hfff));
		send_frame(make_frame(12'hfff, 12'hfff, 12'hfff, 12'h000));
		wait_idle();
	endtask

	// Selection order, clamped count and out-of-range indices.
	task automatic test_selection();
		write_reg(REG_USE_AVERAGE, 8'd0);
		write_reg(REG_SELECT_COUNT, 8'd2);
		write_reg(REG_SELECT_LIST, {2'd0, 2'd2, 2'd1, 2'd3});
		send_frame(make_frame(12'd10, 12'd11, 12'd12, 12'd13));
		wait_idle();
		write_reg(REG_SELECT_COUNT, 8'd7);
		write_reg(REG_SELECT_LIST, {2'd0, 2'd1, 2'd2, 2'd3});
		send_frame(make_frame(12'd20, 12'd21, 12'd22, 12'd23));
		wait_idle();
		// With two channels, indices two and three fall back to channel zero.
		write_reg(REG_CHANNEL_COUNT, 8'd2);
		write_reg(REG_SELECT_COUNT, 8'd4);
		write_reg(REG_SELECT_LIST, {2'd1, 2'd3, 2'd2, 2'd1});
		send_frame(make_frame(12'd30, 12'd31, 12'd32, 12'd33));
		wait_idle();
	endtask

	// Channel count zero acts as one, above four as four; unused indices do nothing.
	task automatic test_channel_limits();
		write_reg(REG_SELECT_COUNT, 8'd0);
		write_reg(REG_CHANNEL_COUNT, 8'd0);
		send_frame(make_frame(12'd40, 12'd41, 12'd42, 12'd43));
		wait_idle();
		write_reg(REG_CHANNEL_COUNT, 8'hff);
		write_reg(REG_USE_AVERAGE, 8'hfe);
		send_frame(make_frame(12'd50, 12'd51, 12'd52, 12'd53));
		wait_idle();
		for (int i = REG_SELECT_LIST + 1; i < (1 << REG_IDX_BITS); i++)
			write_reg(REG_IDX_BITS'(i), 8'hff);
		send_frame(make_frame(12'd60, 12'd61, 12'd62, 12'd63));
		wait_idle();
	endtask

	// The receiver stops for a long stretch so the unit backs up into its input.
	task automatic test_backpressure();
		write_reg(REG_CHANNEL_COUNT, 8'd4);
		write_reg(REG_SELECT_COUNT, 8'd0);
		write_reg(REG_USE_AVERAGE, 8'd0);
		hold_req = 1'b1;
		repeat (12)
			send_frame(rand_frame());
		wait_idle();
	endtask

	task automatic randomize_regs();
		logic [SEL_LIST_BITS-1:0] w;
		if ($urandom_range(3) != 0)
			write_reg(REG_CHANNEL_COUNT, SEL_LIST_BITS'($urandom_range(7)));
		if ($urandom_range(9) < 7) begin
			case ($urandom_range(3))
				0: begin
					case ($urandom_range(3))
						0: w = 8'd0;
						1: w = 8'd1;
						2: w = 8'd16;
						default: w = 8'd31;
					endcase
				end
				1: w = SEL_LIST_BITS'($urandom_range(255));
				default: w = SEL_LIST_BITS'($urandom_range(1, 16));
			endcase
			write_reg(REG_WINDOW_LENGTH, w);
		end
		if ($urandom_range(3) != 0)
			write_reg(REG_USE_AVERAGE, SEL_LIST_BITS'($urandom_range(1)));
		if ($urandom_range(3) != 0)
			write_reg(REG_SELECT_COUNT, SEL_LIST_BITS'($urandom_range(7)));
		if ($urandom_range(3) != 0)
			write_reg(REG_SELECT_LIST, SEL_LIST_BITS'($urandom_range(255)));
	endtask

	// Phases of random frames, each under a new random register setting.
	task automatic test_random_phases();
		int count;
		for (int p = 0; p < 10; p++) begin
			calm = (p == 3);
			randomize_regs();
			count = $urandom_range(30, 56);
			repeat (count)
				send_frame(rand_frame());
			wait_idle();
		end
		calm = 1'b0;
	endtask

	initial begin
		errors = 0;
		frames_sent = 0;
		results_checked = 0;
		reg_writes = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		frame_ch.valid = 1'b0;
		frame_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		result_ch.ready = 1'b0;
		chan_count = CHANNEL_COUNT_RESET;
		use_avg = 0;
		sel_count = 0;
		sel_list = 0;
		restart_ring(WINDOW_RESET);
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_window_average();
		test_selection();
		test_channel_limits();
		test_backpressure();
		test_random_phases();

		wait_idle();
		repeat (200) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d expected results left over", $time, pending_results.size());
			errors++;
		end
		$display("Sent %0d frames and checked %0d result words across %0d register writes,",
			frames_sent, results_checked, reg_writes);
		$display("covering raw and mean modes, window and channel limits and selection orders.");
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
